[sv/psvm_pkg.sv]
package psvm_pkg;

    localparam int BOX_DIM_DEF    = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ADDR_BITS      = 18;
    localparam int FUNC_BITS      = 2;
    localparam int OUT_BITS       = 3;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_PAINT = 2'd0,
        FN_WRITE = 2'd1,
        FN_READ  = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_RAD   = 8'b0000_0100,
        ST_LIM   = 8'b0000_1000,
        ST_THR   = 8'b0001_0000,
        ST_WALK  = 8'b0010_0000,
        ST_DRAIN = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

endpackage

[sv/periodic_sphere_voxel_marker_core.sv]
// Periodic grid of BOX_DIM^3 one-bit voxel flags (1 untaken, 0 taken) held in one
// single-port-write, registered-read memory. After reset the block sweeps the memory to all
// ones, one voxel per cycle, before it accepts its first beat. A write or read beat, an unused
// code or a negative-radius paint goes from idle straight to the done state. A paint beat
// steps through RAD, LIM, THR, WALK, DRAIN and DONE; n = ceil(radius * BOX_DIM) after the radius
// saturates at half the box: the (2n+1)^3 cube around the centre is walked at one voxel per cycle,
// limited by the single memory write port. One beat is worked on at a time; the result
// register lets the next beat in while a result waits on m_tready.
module periodic_sphere_voxel_marker_core import psvm_pkg::*; #(
    parameter int BOX_DIM      = BOX_DIM_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    localparam int IN_BITS     = FUNC_BITS + 4 * FRAC_BITS + 1 + ADDR_BITS + 1,
    localparam int S_TDATA_BITS = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // func, center_x, center_y, center_z, radius, voxel_address, write_flag
    input  logic [S_TDATA_BITS-1:0]   s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // read_flag, done_func
    output logic [OUT_TDATA_BITS-1:0] m_tdata
);

    localparam int F      = FRAC_BITS;
    localparam int CW     = $clog2(BOX_DIM);
    localparam int OW     = CW + 1;
    localparam int SQW    = 2 * CW;
    localparam int SUMW   = SQW + 2;
    localparam int VOXELS = BOX_DIM * BOX_DIM * BOX_DIM;
    localparam int DD     = BOX_DIM * BOX_DIM;
    localparam int AW     = $clog2(VOXELS);
    localparam int XW     = ((AW > ADDR_BITS) ? AW : ADDR_BITS) + 1;
    localparam int RDW    = F + CW;
    localparam int LW     = 2 * RDW;
    localparam int RCW    = F + CW + 1;
    localparam int CX_LO  = FUNC_BITS;
    localparam int CY_LO  = CX_LO + F;
    localparam int CZ_LO  = CY_LO + F;
    localparam int R_LO   = CZ_LO + F;
    localparam int A_LO   = R_LO + F + 1;
    localparam int WF_LO  = A_LO + ADDR_BITS;

    localparam logic signed [CW+1:0] DIM_S   = (CW + 2)'(BOX_DIM);
    localparam logic [F-1:0]         HALF_R  = F'(1) << (F - 1);

    function automatic logic [CW-1:0] round_centre(input logic [F-1:0] f);
        logic [RCW-1:0] p;
        logic [CW:0]    c;
        p = RCW'(f) * RCW'(BOX_DIM) + (RCW'(1) << (F - 1));
        c = p[RCW-1:F];
        if (c >= (CW + 1)'(BOX_DIM)) begin
            c = c - (CW + 1)'(BOX_DIM);
        end
        return c[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] wrap_coord(input logic [CW-1:0] c,
                                                 input logic signed [OW-1:0] o);
        logic signed [CW+1:0] s;
        s = $signed({2'b00, c}) + (CW + 2)'(o);
        if (s < 0) begin
            s = s + DIM_S;
        end else if (s >= DIM_S) begin
            s = s - DIM_S;
        end
        return s[CW-1:0];
    endfunction

    function automatic logic [SQW-1:0] image_sq(input logic signed [OW-1:0] o);
        logic signed [OW-1:0] neg;
        logic [CW-1:0]        d;
        logic [CW:0]          e;
        logic [CW-1:0]        m;
        neg = -o;
        d   = o[OW-1] ? neg[CW-1:0] : o[CW-1:0];
        e   = (CW + 1)'(BOX_DIM) - (CW + 1)'(d);
        m   = (e < (CW + 1)'(d)) ? e[CW-1:0] : d;
        return SQW'(m) * SQW'(m);
    endfunction

    // input beat fields
    func_t                s_func;
    logic [F-1:0]         s_cx, s_cy, s_cz;
    logic [F:0]           s_radius;
    logic [ADDR_BITS-1:0] s_addr;
    logic                 s_wflag;
    logic [XW-1:0]        s_addr_x;
    logic                 s_in_range;
    logic                 s_acc;

    assign s_func     = func_t'(s_tdata[FUNC_BITS-1:0]);
    assign s_cx       = s_tdata[CY_LO-1:CX_LO];
    assign s_cy       = s_tdata[CZ_LO-1:CY_LO];
    assign s_cz       = s_tdata[R_LO-1:CZ_LO];
    assign s_radius   = s_tdata[A_LO-1:R_LO];
    assign s_addr     = s_tdata[WF_LO-1:A_LO];
    assign s_wflag    = s_tdata[WF_LO];
    assign s_addr_x   = XW'(s_addr);
    assign s_in_range = s_addr_x < XW'(VOXELS);

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic signed [OW-1:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic a_vld_reg, a_vld_next;
    logic m_tvalid_reg, m_tvalid_next;

    func_t func_reg, func_next;
    logic range_reg, range_next;
    logic [F-1:0] fx_reg, fx_next, fy_reg, fy_next, fz_reg, fz_next;
    logic [F-1:0] rad_reg, rad_next;
    logic [CW-1:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [RDW-1:0] rd_reg, rd_next;
    logic [LW-1:0] lim_reg, lim_next;
    logic [CW-1:0] n_reg, n_next;
    logic [SQW-1:0] thr_reg, thr_next;
    logic [CW-1:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic [SQW-1:0] sqx_reg, sqx_next, sqy_reg, sqy_next, sqz_reg, sqz_next;
    logic res_flag_reg, res_flag_next;
    logic [FUNC_BITS-1:0] res_func_reg, res_func_next;

    logic ram_we, ram_wdata, ram_re, ram_rdata;
    logic [AW-1:0] ram_waddr, ram_raddr;

    logic [RDW:0] n_sum;
    logic [LW:0] thr_sum;
    logic signed [OW-1:0] n_s, neg_n;
    logic last_x, last_y, last_z;
    logic [SUMW-1:0] dist_sq;
    logic walk_hit;
    logic [AW-1:0] walk_addr;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_BITS - OUT_BITS){1'b0}}, res_func_reg, res_flag_reg};

    assign n_sum   = (RDW + 1)'(rd_reg) + (RDW + 1)'({F{1'b1}});
    assign thr_sum = (LW + 1)'(lim_reg) + (LW + 1)'({(2 * F){1'b1}});
    assign n_s     = $signed({1'b0, n_reg});
    assign neg_n   = -n_s;
    assign last_x  = (ox_reg == n_s);
    assign last_y  = (oy_reg == n_s);
    assign last_z  = (oz_reg == n_s);

    assign dist_sq   = SUMW'(sqx_reg) + SUMW'(sqy_reg) + SUMW'(sqz_reg);
    assign walk_hit  = dist_sq < SUMW'(thr_reg);
    assign walk_addr = AW'(ax_reg) * AW'(DD) + AW'(ay_reg) * AW'(BOX_DIM) + AW'(az_reg);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = 1'b0;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = 1'b1;
        end else if (a_vld_reg) begin
            ram_we    = walk_hit;
            ram_waddr = walk_addr;
        end else if (s_acc && s_func == FN_WRITE && s_in_range) begin
            ram_we    = 1'b1;
            ram_waddr = s_addr_x[AW-1:0];
            ram_wdata = s_wflag;
        end
    end

    assign ram_re    = s_acc && s_func == FN_READ && s_in_range;
    assign ram_raddr = s_addr_x[AW-1:0];

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        oz_next       = oz_reg;
        a_vld_next    = 1'b0;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        func_next     = func_reg;
        range_next    = range_reg;
        fx_next       = fx_reg;
        fy_next       = fy_reg;
        fz_next       = fz_reg;
        rad_next      = rad_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        rd_next       = rd_reg;
        lim_next      = lim_reg;
        n_next        = n_reg;
        thr_next      = thr_reg;
        ax_next       = wrap_coord(cx_reg, ox_reg);
        ay_next       = wrap_coord(cy_reg, oy_reg);
        az_next       = wrap_coord(cz_reg, oz_reg);
        sqx_next      = image_sq(ox_reg);
        sqy_next      = image_sq(oy_reg);
        sqz_next      = image_sq(oz_reg);
        res_flag_next = res_flag_reg;
        res_func_next = res_func_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(VOXELS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    func_next  = s_func;
                    range_next = s_in_range;
                    fx_next    = s_cx;
                    fy_next    = s_cy;
                    fz_next    = s_cz;
                    rad_next   = (s_radius[F-1:0] > HALF_R) ? HALF_R : s_radius[F-1:0];
                    unique case (s_func) inside
                        FN_PAINT: begin
                            state_next = s_radius[F] ? ST_DONE : ST_RAD;
                        end
                        FN_WRITE, FN_READ, FN_NONE: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RAD: begin
                cx_next    = round_centre(fx_reg);
                cy_next    = round_centre(fy_reg);
                cz_next    = round_centre(fz_reg);
                rd_next    = RDW'(rad_reg) * RDW'(BOX_DIM);
                state_next = ST_LIM;
            end
            ST_LIM: begin
                lim_next   = LW'(rd_reg) * LW'(rd_reg);
                n_next     = n_sum[F+CW-1:F];
                state_next = ST_THR;
            end
            ST_THR: begin
                thr_next   = thr_sum[2*F+SQW-1:2*F];
                ox_next    = neg_n;
                oy_next    = neg_n;
                oz_next    = neg_n;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                a_vld_next = 1'b1;
                if (!last_z) begin
                    oz_next = oz_reg + OW'(1);
                end else begin
                    oz_next = neg_n;
                    if (!last_y) begin
                        oy_next = oy_reg + OW'(1);
                    end else begin
                        oy_next = neg_n;
                        ox_next = ox_reg + OW'(1);
                        if (last_x) begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    res_func_next = func_reg;
                    res_flag_next = (func_reg == FN_READ) && range_reg && ram_rdata;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            ox_reg       <= '0;
            oy_reg       <= '0;
            oz_reg       <= '0;
            a_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            ox_reg       <= ox_next;
            oy_reg       <= oy_next;
            oz_reg       <= oz_next;
            a_vld_reg    <= a_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        range_reg    <= range_next;
        fx_reg       <= fx_next;
        fy_reg       <= fy_next;
        fz_reg       <= fz_next;
        rad_reg      <= rad_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        rd_reg       <= rd_next;
        lim_reg      <= lim_next;
        n_reg        <= n_next;
        thr_reg      <= thr_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        az_reg       <= az_next;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        sqz_reg      <= sqz_next;
        res_flag_reg <= res_flag_next;
        res_func_reg <= res_func_next;
    end

    psvm_ram #(
        .WIDTH(1),
        .DEPTH(VOXELS)
    ) u_flags (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[sv/psvm_ram.sv]
module psvm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
